// File: rtl/core/window_feature_extractor_assert.svh
// Assertion macros for the window feature extractor.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef WINDOW_FEATURE_EXTRACTOR_ASSERT_SVH
`define WINDOW_FEATURE_EXTRACTOR_ASSERT_SVH

// Condition must never hold outside reset.
`define FWE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Same-cycle implication.
`define FWE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/fwe_pkg.sv
// Shared types and constants of the window feature extractor.
// No dependencies; imported by every module of the block except fwe_divider.
`timescale 1ns / 1ps
`default_nettype none

package fwe_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam int WLEN_W      = 9;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int TOTAL_W     = 25;
  localparam int SQUARES_W   = 39;
  localparam int CROSS_W     = 8;
  localparam int Q_FRAC      = 8;
  localparam int MAG_W       = 24;
  localparam int PROD_W      = 47;
  localparam int NSQ_W       = 2 * COUNT_W;
  localparam int MEAN_NUM_W  = MAG_W + Q_FRAC;
  localparam int VAR_NUM_W   = PROD_W + Q_FRAC;
  localparam int AVG_W       = 24;
  localparam int SPREAD_W    = 39;

  localparam logic [WLEN_W-1:0]         WLEN_RESET   = WLEN_W'(64);
  localparam logic signed [SAMPLE_BITS-1:0] THRESH_RESET = SAMPLE_BITS'(40);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CROSSING_THRESHOLD = CFG_INDEX_W'(1);

  // accumulated state of one closed window
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] low;
    logic signed [SAMPLE_BITS-1:0] high;
    logic signed [TOTAL_W-1:0]     total;
    logic [SQUARES_W-1:0]          squares;
    logic [CROSS_W-1:0]            crossings;
    logic [COUNT_W-1:0]            n;
  } window_snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_MUL,
    B_SUB,
    B_DIV
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/fwe_front.sv
// Front end: config registers, window counting and per-sample accumulation.
// Depends on fwe_pkg; pushes one window_snap_t per closed window.
`timescale 1ns / 1ps
`default_nettype none

module fwe_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [fwe_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [fwe_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [fwe_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  fwe_pkg::queue_status_t                q_status,
  output logic                                  push,
  output fwe_pkg::window_snap_t                 snap
);
  import fwe_pkg::*;

  logic [WLEN_W-1:0]             window_length;
  logic signed [SAMPLE_BITS-1:0] crossing_threshold;
  logic [COUNT_W-1:0]            len_eff;

  logic [COUNT_W-1:0]            seen;
  logic [COUNT_W-1:0]            count_inc;
  logic                          close_now;
  logic                          accept;
  logic signed [SQ_W-1:0]        sq_signed;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic [SQ_W-1:0]               s1_sq;
  logic                          s1_below;
  logic                          s1_first;
  logic                          s1_close;
  logic [COUNT_W-1:0]            s1_n;
  logic                          s1_advance;

  logic signed [SAMPLE_BITS-1:0] low, low_next;
  logic signed [SAMPLE_BITS-1:0] high, high_next;
  logic signed [TOTAL_W-1:0]     total, total_next;
  logic [SQUARES_W-1:0]          squares, squares_next;
  logic                          last_below;
  logic [CROSS_W-1:0]            crossings, crossings_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length      <= WLEN_RESET;
      crossing_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:      window_length      <= cfg_data[WLEN_W-1:0];
        REG_CROSSING_THRESHOLD: crossing_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, long lengths clamp to the maximum
  always_comb begin
    if (window_length == '0) begin
      len_eff = COUNT_W'(1);
    end else if (COUNT_W'(window_length) > COUNT_W'(MAX_WINDOW)) begin
      len_eff = COUNT_W'(MAX_WINDOW);
    end else begin
      len_eff = COUNT_W'(window_length);
    end
  end

  assign count_inc    = seen + COUNT_W'(1);
  assign close_now    = count_inc >= len_eff;
  assign sq_signed    = sample * sample;
  assign s1_advance   = s1_valid && !(s1_close && q_status.full);
  assign sample_ready = !s1_valid || s1_advance;
  assign accept       = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (sample_ready) s1_valid <= sample_valid;
      if (accept) seen <= close_now ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x     <= sample;
      s1_sq    <= unsigned'(sq_signed);
      s1_below <= sample < crossing_threshold;
      s1_first <= seen == '0;
      s1_close <= close_now;
      s1_n     <= count_inc;
    end
  end

  always_comb begin
    low_next       = (s1_first || s1_x < low)  ? s1_x : low;
    high_next      = (s1_first || s1_x > high) ? s1_x : high;
    total_next     = total + TOTAL_W'(s1_x);
    squares_next   = squares + SQUARES_W'(s1_sq);
    crossings_next = crossings;
    if (!s1_first && s1_below != last_below && crossings != {CROSS_W{1'b1}})
      crossings_next = crossings + CROSS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low        <= '0;
      high       <= '0;
      total      <= '0;
      squares    <= '0;
      last_below <= 1'b0;
      crossings  <= '0;
    end else if (s1_advance) begin
      if (s1_close) begin
        low        <= '0;
        high       <= '0;
        total      <= '0;
        squares    <= '0;
        last_below <= 1'b0;
        crossings  <= '0;
      end else begin
        low        <= low_next;
        high       <= high_next;
        total      <= total_next;
        squares    <= squares_next;
        last_below <= s1_below;
        crossings  <= crossings_next;
      end
    end
  end

  assign push           = s1_advance && s1_close;
  assign snap.low       = low_next;
  assign snap.high      = high_next;
  assign snap.total     = total_next;
  assign snap.squares   = squares_next;
  assign snap.crossings = crossings_next;
  assign snap.n         = s1_n;

endmodule

`default_nettype wire

// File: rtl/core/fwe_queue.sv
// Short FIFO of closed-window snapshots between front and back.
// Depends on fwe_pkg for window_snap_t and queue_status_t.
`timescale 1ns / 1ps
`default_nettype none

module fwe_queue #(
  parameter int DEPTH = fwe_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  fwe_pkg::window_snap_t  push_data,
  input  logic                   pop,
  output fwe_pkg::window_snap_t  head,
  output fwe_pkg::queue_status_t status
);
  import fwe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  window_snap_t     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = count == CNT_W'(DEPTH);
  assign status.empty = count == '0;

endmodule

`default_nettype wire

// File: rtl/core/fwe_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; quotient and remainder hold after busy falls.
`timescale 1ns / 1ps
`default_nettype none

module fwe_divider #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(NUM_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// File: rtl/core/fwe_back.sv
// Back end: per-window mean and variance, result register.
// Depends on fwe_pkg and fwe_divider.
`timescale 1ns / 1ps
`default_nettype none

module fwe_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fwe_pkg::queue_status_t                 q_status,
  input  fwe_pkg::window_snap_t                  head,
  output logic                                   pop,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [fwe_pkg::SAMPLE_BITS-1:0] window_min,
  output logic signed [fwe_pkg::SAMPLE_BITS-1:0] window_max,
  output logic [fwe_pkg::SAMPLE_BITS-1:0]        peak_span,
  output logic signed [fwe_pkg::AVG_W-1:0]       average_q8,
  output logic [fwe_pkg::SPREAD_W-1:0]           spread_q8,
  output logic [fwe_pkg::SQUARES_W-1:0]          square_sum,
  output logic [fwe_pkg::CROSS_W-1:0]            crossing_count
);
  import fwe_pkg::*;

  localparam int MBIT_W = $clog2(COUNT_W);

  back_state_t state, state_next;

  window_snap_t        win;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   tsq;
  logic [NSQ_W-1:0]    nsq;
  logic [MBIT_W-1:0]   mbit;

  logic [TOTAL_W-1:0]    tot_abs;
  logic [MAG_W-1:0]      mag;
  logic [2*MAG_W-1:0]    mag_sq;
  logic [NSQ_W-1:0]      n_sq;
  logic [PROD_W-1:0]     var_num;
  logic [MEAN_NUM_W-1:0] avg_full;

  logic                  mean_start, var_start, load;
  logic                  mean_busy, var_busy;
  logic [MEAN_NUM_W-1:0] mean_q;
  logic [COUNT_W-1:0]    mean_r;
  logic [VAR_NUM_W-1:0]  var_q;
  logic [NSQ_W-1:0]      var_r;

  assign tot_abs = win.total[TOTAL_W-1] ? unsigned'(-win.total) : unsigned'(win.total);
  assign mag     = tot_abs[MAG_W-1:0];
  assign mag_sq  = mag * mag;
  assign n_sq    = win.n * win.n;
  assign var_num = prod - tsq;

  // floor toward minus infinity: -q when exact, ~q (= -q-1) otherwise
  always_comb begin
    if (win.total[TOTAL_W-1]) avg_full = (mean_r != '0) ? ~mean_q : -mean_q;
    else                      avg_full = mean_q;
  end

  fwe_divider #(
    .NUM_W(MEAN_NUM_W),
    .DEN_W(COUNT_W)
  ) u_mean_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mean_start),
    .dividend ({mag, {Q_FRAC{1'b0}}}),
    .divisor  (win.n),
    .busy     (mean_busy),
    .quotient (mean_q),
    .remainder(mean_r)
  );

  fwe_divider #(
    .NUM_W(VAR_NUM_W),
    .DEN_W(NSQ_W)
  ) u_var_div (
    .clk      (clk),
    .rst      (rst),
    .start    (var_start),
    .dividend ({var_num, {Q_FRAC{1'b0}}}),
    .divisor  (nsq),
    .busy     (var_busy),
    .quotient (var_q),
    .remainder(var_r)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mean_start = 1'b0;
    var_start  = 1'b0;
    load       = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = B_PREP;
        end
      end
      B_PREP: begin
        mean_start = 1'b1;
        state_next = B_MUL;
      end
      B_MUL: begin
        if (mbit == '0) state_next = B_SUB;
      end
      B_SUB: begin
        var_start  = 1'b1;
        state_next = B_DIV;
      end
      B_DIV: begin
        if (!mean_busy && !var_busy && (!result_valid || result_ready)) begin
          load       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // n * sumsq by shift-and-add, MSB of n first
  always_ff @(posedge clk) begin
    if (pop) win <= head;
    case (state)
      B_PREP: begin
        tsq  <= mag_sq[PROD_W-1:0];
        nsq  <= n_sq;
        prod <= '0;
        mbit <= MBIT_W'(COUNT_W - 1);
      end
      B_MUL: begin
        prod <= (prod << 1) + (win.n[mbit] ? PROD_W'(win.squares) : '0);
        mbit <= mbit - MBIT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      window_min     <= win.low;
      window_max     <= win.high;
      peak_span      <= unsigned'(win.high - win.low);
      average_q8     <= signed'(avg_full[AVG_W-1:0]);
      spread_q8      <= var_q[SPREAD_W-1:0] | SPREAD_W'(var_r & '0);
      square_sum     <= win.squares;
      crossing_count <= win.crossings;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/window_feature_extractor.sv
// Window feature extractor: min, max, span, Q8 mean, Q8 variance, energy, crossings.
// Takes one sample per cycle while sample_ready is high; a window's result follows its last
// sample through push, pop, prep, shift-add n*sumsq, subtract, divide and result load.
// The back unit takes one window at a time, held by result stalls; shorter windows stall the
// sample input once the snapshot queue is full. Reset (rst, synchronous) restores
// window_length 64 and crossing_threshold 40 and drops any partial window.
`timescale 1ns / 1ps
`default_nettype none

module window_feature_extractor #(
  parameter int QUEUE_DEPTH = fwe_pkg::QUEUE_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration writes, taken whenever cfg_we is high
  input  logic                                   cfg_we,
  input  logic [fwe_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [fwe_pkg::CFG_DATA_W-1:0]         cfg_data,
  // sample channel
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic signed [fwe_pkg::SAMPLE_BITS-1:0] sample,
  // result channel
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [fwe_pkg::SAMPLE_BITS-1:0] window_min,
  output logic signed [fwe_pkg::SAMPLE_BITS-1:0] window_max,
  output logic [fwe_pkg::SAMPLE_BITS-1:0]        peak_span,
  output logic signed [fwe_pkg::AVG_W-1:0]       average_q8,
  output logic [fwe_pkg::SPREAD_W-1:0]           spread_q8,
  output logic [fwe_pkg::SQUARES_W-1:0]          square_sum,
  output logic [fwe_pkg::CROSS_W-1:0]            crossing_count
);
  import fwe_pkg::*;

  // Front: registers the sample with its square and window position, then
  // folds it into the running min/max/sum/sumsq/crossings. The closing item
  // pushes a snapshot of the finished window and clears the accumulators.
  window_snap_t  push_snap;
  window_snap_t  head_snap;
  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;

  fwe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .q_status    (q_status),
    .push        (q_push),
    .snap        (push_snap)
  );

  // Snapshot queue: lets the front keep collecting the next window while the
  // back is still dividing the previous one.
  fwe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(push_snap),
    .pop      (q_pop),
    .head     (head_snap),
    .status   (q_status)
  );

  // Back: sequencer with shift-add multiply and two serial dividers; the
  // result register frees it to pick up the next window's arithmetic.
  fwe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .head          (head_snap),
    .pop           (q_pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .window_min    (window_min),
    .window_max    (window_max),
    .peak_span     (peak_span),
    .average_q8    (average_q8),
    .spread_q8     (spread_q8),
    .square_sum    (square_sum),
    .crossing_count(crossing_count)
  );

  `include "window_feature_extractor_assert.svh"

  `FWE_ASSERT_IMPLY(a_no_push_when_full, q_push, !q_status.full, "push into full queue")
  `FWE_ASSERT_IMPLY(a_no_pop_when_empty, q_pop, !q_status.empty, "pop from empty queue")
  `FWE_ASSERT_NEXT(a_pop_spaced, q_pop, !q_pop, "back popped on consecutive cycles")
  `FWE_ASSERT_IMPLY(a_min_le_max, result_valid, window_min <= window_max, "min above max")

endmodule

`default_nettype wire

// File: bench/tb_window_feature_extractor.sv
`timescale 1ns / 1ps
// Self-checking bench for window_feature_extractor: directed table, then random windows.
// Depends on fwe_pkg and the window_feature_extractor RTL only.

module tb_window_feature_extractor;
  import fwe_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 5;
  // wait after the last owed result, with margin for the back stage to drain
  localparam int SETTLE_CYCLES  = 100;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int DIRECTED_ROWS  = 28;
  localparam int RANDOM_PHASES  = 13;
  localparam int PHASE_ITEMS    = 65;
  localparam int SWING_ITEMS    = 256;

  // indexes with no register behind them; writes must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_t;

  typedef enum logic [1:0] {
    PAT_UNIFORM,
    PAT_EXTREME,
    PAT_NEAR,
    PAT_SWING
  } pattern_t;

  // one closed window as seen on the result channel
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic [SAMPLE_BITS-1:0]        span;
    logic signed [AVG_W-1:0]       average;
    logic [SPREAD_W-1:0]           spread;
    logic [SQUARES_W-1:0]          energy;
    logic [CROSS_W-1:0]            crossings;
  } window_features_t;

  // directed table row: a register write or a sample; typed rows carry the
  // closed-window result written out by hand
  typedef struct packed {
    row_kind_t                     kind;
    logic [CFG_INDEX_W-1:0]        index;
    logic [CFG_DATA_W-1:0]         data;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          typed;
    window_features_t              want;
  } script_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          sample_valid = 1'b0;
  logic                          sample_ready;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic signed [SAMPLE_BITS-1:0] window_max;
  logic [SAMPLE_BITS-1:0]        peak_span;
  logic signed [AVG_W-1:0]       average_q8;
  logic [SPREAD_W-1:0]           spread_q8;
  logic [SQUARES_W-1:0]          square_sum;
  logic [CROSS_W-1:0]            crossing_count;

  // idle rates in percent per cycle
  int send_gap_pct   = 16;
  int recv_stall_pct = 52;
  int mismatch_count = 0;

  // windows closed by the predictor, oldest first
  window_features_t pending_windows[$];
  script_row_t      script [DIRECTED_ROWS];

  // predictor copy of the registers and the open window
  logic [WLEN_W-1:0]             len_reg    = WLEN_RESET;
  logic signed [SAMPLE_BITS-1:0] thresh_reg = THRESH_RESET;
  int                            win_count  = 0;
  logic signed [SAMPLE_BITS-1:0] win_low    = '0;
  logic signed [SAMPLE_BITS-1:0] win_high   = '0;
  longint                        win_sum    = 0;
  longint unsigned               win_energy = 0;
  bit                            win_below  = 1'b0;
  int                            win_cross  = 0;

  window_feature_extractor u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .window_min    (window_min),
    .window_max    (window_max),
    .peak_span     (peak_span),
    .average_q8    (average_q8),
    .spread_q8     (spread_q8),
    .square_sum    (square_sum),
    .crossing_count(crossing_count)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void note_register(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WINDOW_LENGTH:      len_reg = data[WLEN_W-1:0];
      REG_CROSSING_THRESHOLD: thresh_reg = data;
      default: ;  // spare indexes are dropped
    endcase
  endfunction

  // Folds one sample into the open window. Returns 1 and the features when
  // the window closes on this sample.
  function automatic bit absorb_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                       output window_features_t f);
    int              eff_len;
    bit              below;
    longint          scaled;
    longint          mean;
    longint unsigned n;
    longint unsigned mag;
    longint unsigned num;
    longint unsigned var_q8;
    // zero length means one; anything past the max is clamped
    if (len_reg == 0) eff_len = 1;
    else if (len_reg > MAX_WINDOW) eff_len = MAX_WINDOW;
    else eff_len = int'(len_reg);
    below = (x < thresh_reg);
    // the first sample seeds min/max and the below flag and counts no crossing
    if (win_count == 0) begin
      win_low  = x;
      win_high = x;
    end else begin
      if (x < win_low) win_low = x;
      if (x > win_high) win_high = x;
      if (below != win_below && win_cross < 255) win_cross++;
    end
    win_below  = below;
    win_sum    += longint'(x);
    win_energy += longint'(x) * longint'(x);
    win_count++;
    f = '0;
    // a shortened length closes the window once the count reaches it
    if (win_count < eff_len) return 1'b0;
    n      = win_count;
    // Q8 mean, floor toward minus infinity (division truncates toward zero)
    scaled = win_sum * 256;
    mean   = scaled / longint'(n);
    if ((scaled % longint'(n)) != 0 && scaled < 0) mean--;
    // Q8 population variance: 256*(n*sumsq - sum^2) / n^2, floored
    mag    = (win_sum < 0) ? -win_sum : win_sum;
    num    = n * win_energy - mag * mag;
    var_q8 = (num * 256) / (n * n);
    f.minimum   = win_low;
    f.maximum   = win_high;
    f.span      = SAMPLE_BITS'(win_high - win_low);
    f.average   = mean[AVG_W-1:0];
    f.spread    = var_q8[SPREAD_W-1:0];
    f.energy    = win_energy[SQUARES_W-1:0];
    f.crossings = CROSS_W'(win_cross);
    win_count  = 0;
    win_low    = '0;
    win_high   = '0;
    win_sum    = 0;
    win_energy = 0;
    win_below  = 1'b0;
    win_cross  = 0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Table helpers and stimulus pickers
  // ---------------------------------------------------------------------------

  function automatic window_features_t features(
    input logic signed [SAMPLE_BITS-1:0] mn, input logic signed [SAMPLE_BITS-1:0] mx,
    input logic [SAMPLE_BITS-1:0] span, input logic signed [AVG_W-1:0] avg,
    input logic [SPREAD_W-1:0] spread, input logic [SQUARES_W-1:0] energy,
    input logic [CROSS_W-1:0] crossings);
    window_features_t f;
    f.minimum   = mn;
    f.maximum   = mx;
    f.span      = span;
    f.average   = avg;
    f.spread    = spread;
    f.energy    = energy;
    f.crossings = crossings;
    return f;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.data  = data;
    return r;
  endfunction

  function automatic script_row_t sample_row(input logic signed [SAMPLE_BITS-1:0] v);
    script_row_t r;
    r       = '0;
    r.kind  = ROW_SAMPLE;
    r.value = v;
    return r;
  endfunction

  function automatic script_row_t typed_row(input logic signed [SAMPLE_BITS-1:0] v,
                                            input window_features_t w);
    script_row_t r;
    r       = sample_row(v);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic logic [WLEN_W-1:0] pick_length();
    case ($urandom_range(9))
      0:       return '0;
      1:       return WLEN_W'(1);
      2:       return WLEN_W'(MAX_WINDOW);
      3:       return WLEN_W'($urandom_range(511, MAX_WINDOW + 1));
      4:       return WLEN_W'($urandom_range(MAX_WINDOW - 1, 25));
      default: return WLEN_W'($urandom_range(24, 2));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    case ($urandom_range(3))
      0:       return CFG_DATA_W'($urandom);
      1:       return 16'h8000;
      2:       return 16'h7FFF;
      default: return CFG_DATA_W'($urandom_range(400) - 200);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input pattern_t p,
                                                               input int k);
    case (p)
      PAT_EXTREME:
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return '0;
          default: return '1;
        endcase
      // hug the threshold so the below flag flips often, edges included
      PAT_NEAR:  return SAMPLE_BITS'(thresh_reg + $urandom_range(6) - 3);
      // full-scale square wave
      PAT_SWING: return k[0] ? 16'sh7FFF : 16'sh8000;
      default:   return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. Tasks are entered and left right after a rising edge.
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    note_register(idx, data);
    @(posedge clk);
  endtask

  // Offers one sample; valid stays up across back-to-back items and only
  // drops when a gap is taken.
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] x, input bit typed,
                             input window_features_t typed_want);
    int               gap;
    bit               closed;
    window_features_t predicted;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= x;
    // ready is sampled mid-cycle, away from the edge where it may change
    @(negedge clk);
    while (!sample_ready) @(negedge clk);
    @(posedge clk);
    closed = absorb_sample(x, predicted);
    if (typed) pending_windows.push_back(typed_want);
    else if (closed) pending_windows.push_back(predicted);
  endtask

  // Quiet the sample channel, wait for every owed result, then let the back
  // stage run dry so a register write lands on an idle block.
  task automatic settle_block();
    sample_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checking, mid-cycle so outputs are settled
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk) begin : result_check
    window_features_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_windows.size() == 0) begin
        $error("result item with no window pending");
        mismatch_count++;
      end else begin
        want = pending_windows.pop_front();
        check_field("window_min", want.minimum, window_min);
        check_field("window_max", want.maximum, window_max);
        check_field("peak_span", want.span, peak_span);
        check_field("average_q8", want.average, average_q8);
        check_field("spread_q8", want.spread, spread_q8);
        check_field("square_sum", want.energy, square_sum);
        check_field("crossing_count", want.crossings, crossing_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    pattern_t pattern;
    int       items;

    script = '{
      // single-sample windows at full scale and zero
      reg_row(REG_WINDOW_LENGTH, 16'd1),
      typed_row(16'sh7FFF, features(16'sh7FFF, 16'sh7FFF, 16'd0, 24'sd8388352,
                                    39'd0, 39'd1073676289, 8'd0)),
      typed_row(16'sh8000, features(16'sh8000, 16'sh8000, 16'd0, 24'sh800000,
                                    39'd0, 39'd1073741824, 8'd0)),
      typed_row(16'sd0, features(16'sd0, 16'sd0, 16'd0, 24'sd0, 39'd0, 39'd0, 8'd0)),
      // length zero behaves as one
      reg_row(REG_WINDOW_LENGTH, 16'd0),
      typed_row(-16'sd1, features(-16'sd1, -16'sd1, 16'd0, -24'sd256, 39'd0, 39'd1, 8'd0)),
      // full-span pair under the reset threshold, then the strict-less edge
      reg_row(REG_WINDOW_LENGTH, 16'd2),
      sample_row(16'sh7FFF),
      typed_row(16'sh8000, features(16'sh8000, 16'sh7FFF, 16'hFFFF, -24'sd128,
                                    39'd274869518400, 39'd2147418113, 8'd1)),
      sample_row(16'sd40),
      typed_row(16'sd39, features(16'sd39, 16'sd40, 16'd1, 24'sd10112,
                                  39'd64, 39'd3121, 8'd1)),
      // lowest threshold: nothing is below; length 3 through masked upper bits;
      // spare indexes must leave both registers alone
      reg_row(REG_CROSSING_THRESHOLD, 16'h8000),
      reg_row(REG_WINDOW_LENGTH, 16'hFE03),
      reg_row(REG_SPARE_2, 16'h0001),
      reg_row(REG_SPARE_3, 16'hFFFF),
      sample_row(16'sh8000),
      sample_row(16'sd0),
      typed_row(16'sh8000, features(16'sh8000, 16'sd0, 16'h8000, -24'sd5592406,
                                    39'd61083979320, 39'd2147483648, 8'd0)),
      // highest threshold: only the max sample is not below
      reg_row(REG_CROSSING_THRESHOLD, 16'h7FFF),
      sample_row(16'sh7FFF),
      sample_row(16'sh7FFE),
      sample_row(16'sh7FFF),
      // shrink the length under a partly filled window
      reg_row(REG_WINDOW_LENGTH, 16'd8),
      sample_row(16'sd100),
      sample_row(-16'sd100),
      sample_row(16'sd5),
      reg_row(REG_WINDOW_LENGTH, 16'd2),
      sample_row(16'sd7)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle_block();
        write_reg(script[i].index, script[i].data);
      end else begin
        push_sample(script[i].value, script[i].typed, script[i].want);
      end
    end

    // Random phases. Idle mix: sender-light/receiver-heavy, then swapped,
    // then both sides flat out. Phase 0 is one full-length square-wave
    // window, which hits the largest span, variance and crossing count.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph <= 4) begin
        send_gap_pct   = 16;
        recv_stall_pct = 52;
      end else if (ph <= 8) begin
        send_gap_pct   = 52;
        recv_stall_pct = 16;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      settle_block();
      if (ph == 0) begin
        write_reg(REG_WINDOW_LENGTH, 16'hFFFF);  // 511, clamped to the max
        write_reg(REG_CROSSING_THRESHOLD, 16'h0000);
        pattern = PAT_SWING;
        items   = SWING_ITEMS;
      end else begin
        // random upper data bits check that only the low 9 are kept
        write_reg(REG_WINDOW_LENGTH, {7'($urandom), pick_length()});
        write_reg(REG_CROSSING_THRESHOLD, pick_threshold());
        if ($urandom_range(2) == 0)
          write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
        case ($urandom_range(5))
          3:       pattern = PAT_EXTREME;
          4:       pattern = PAT_NEAR;
          5:       pattern = PAT_SWING;
          default: pattern = PAT_UNIFORM;
        endcase
        items = PHASE_ITEMS;
      end
      // a window left open here closes under the next phase's settings
      for (int k = 0; k < items; k++)
        push_sample(pick_sample(pattern, k), 1'b0, '0);
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/fwe_pkg.sv
rtl/core/fwe_front.sv
rtl/core/fwe_queue.sv
rtl/core/fwe_divider.sv
rtl/core/fwe_back.sv
rtl/core/window_feature_extractor.sv
bench/tb_window_feature_extractor.sv
